// ----- src/detector_anchor_decode_filter_top_defines.svh -----
// ----------------------------------------------------------------------------
// Detector anchor decode filter: assertion macros
// Concurrent assertion helpers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef DETECTOR_ANCHOR_DECODE_FILTER_TOP_DEFINES_SVH
`define DETECTOR_ANCHOR_DECODE_FILTER_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, clocked by clk and disabled in reset
`define DADF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dadf assertion failed");
// next-cycle implication
`define DADF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dadf assertion failed");
`else
`define DADF_ASSERT_IMP(lbl, ante, cons)
`define DADF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- src/dadf_pkg.sv -----
// ----------------------------------------------------------------------------
// Detector anchor decode filter package
// Shared widths, register indexes, sequencer states and divider request type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package dadf_pkg;

    localparam int MAX_CLASSES = 128;
    localparam int FRAC_BITS   = 16;
    localparam int MAX_DIM     = 4096;

    localparam int ELEM_W  = 32;
    localparam int THR_W   = 17;
    localparam int NC_W    = 8;
    localparam int DIM_W   = 13;
    localparam int CLS_W   = 7;
    localparam int POS_W   = 8;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 17;
    localparam int MUL_A_W = 36;
    localparam int PROD_W  = 50;
    localparam int DIV_W   = 34;
    localparam int QSH     = FRAC_BITS + 1;

    // register indexes
    localparam logic [IDX_W-1:0] REG_CONF_THR  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SCORE_THR = 3'd1;
    localparam logic [IDX_W-1:0] REG_NUM_CLS   = 3'd2;
    localparam logic [IDX_W-1:0] REG_IMG_W     = 3'd3;
    localparam logic [IDX_W-1:0] REG_IMG_H     = 3'd4;
    localparam logic [IDX_W-1:0] REG_NET_W     = 3'd5;
    localparam logic [IDX_W-1:0] REG_NET_H     = 3'd6;

    localparam logic [THR_W-1:0] CONF_RST  = 17'd16384;
    localparam logic [THR_W-1:0] SCORE_RST = 17'd32768;
    localparam logic [NC_W-1:0]  NC_RST    = 8'd80;
    localparam logic [DIM_W-1:0] DIM_RST   = 13'd640;
    localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(MAX_DIM);
    localparam logic [NC_W-1:0]  NC_MAX    = NC_W'(MAX_CLASSES);
    localparam logic [ELEM_W-1:0] ONE_FIX  = ELEM_W'(1 << FRAC_BITS);

    typedef enum logic [4:0] {
        ST_ELEM,
        ST_RATIO_A,
        ST_RATIO_B,
        ST_SEL,
        ST_XO_A,
        ST_XO_B,
        ST_XO_C,
        ST_YO_A,
        ST_YO_B,
        ST_YO_C,
        ST_X1,
        ST_X2,
        ST_Y1,
        ST_Y2,
        ST_Y3,
        ST_DSTART,
        ST_DWAIT,
        ST_CHECK
    } dadf_state_t;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [DIM_W-1:0]   divisor;
    } dadf_div_req_t;

    // clamp an image or network dimension into 1..MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0)
            r = DIM_W'(1);
        else if (d > DIM_MAX)
            r = DIM_MAX;
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/dadf_in_if.sv -----
// ----------------------------------------------------------------------------
// Element stream interface
// Valid/ready channel carrying one record element.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface dadf_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [dadf_pkg::ELEM_W-1:0]  element_value;
    logic                                record_start;

    modport source (output valid, element_value, record_start, input ready);
    modport sink   (input valid, element_value, record_start, output ready);
endinterface
`default_nettype wire

// ----- src/dadf_out_if.sv -----
// ----------------------------------------------------------------------------
// Candidate stream interface
// Valid/ready channel carrying one decoded detection candidate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface dadf_out_if;
    logic                             valid;
    logic                             ready;
    logic [dadf_pkg::CLS_W-1:0]       cls_index;
    logic [dadf_pkg::THR_W-1:0]       confidence;
    logic [dadf_pkg::DIM_W-2:0]       box_left;
    logic [dadf_pkg::DIM_W-2:0]       box_top;
    logic [dadf_pkg::DIM_W-1:0]       box_width;
    logic [dadf_pkg::DIM_W-1:0]       box_height;

    modport source (output valid, cls_index, confidence, box_left, box_top,
                    box_width, box_height, input ready);
    modport sink   (input valid, cls_index, confidence, box_left, box_top,
                    box_width, box_height, output ready);
endinterface
`default_nettype wire

// ----- src/dadf_div.sv -----
// ----------------------------------------------------------------------------
// Detector anchor decode filter: iterative divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dadf_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dadf_pkg::dadf_div_req_t       req,
    output logic                               busy,
    output logic                               done,
    output logic [dadf_pkg::DIV_W-1:0]         quotient
);

    localparam int CNT_W = $clog2(dadf_pkg::DIV_W + 1);

    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        done_reg, done_next;
    logic [dadf_pkg::DIV_W-1:0]  quo_reg, quo_next;
    logic [dadf_pkg::DIM_W:0]    rem_reg, rem_next;
    logic [dadf_pkg::DIM_W-1:0]  dvs_reg, dvs_next;
    logic [dadf_pkg::DIM_W:0]    trial;

    // one restoring step per cycle
    always_comb
    begin
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        done_next = 1'b0;
        trial     = {rem_reg[dadf_pkg::DIM_W-1:0], quo_reg[dadf_pkg::DIV_W-1]};
        if (req.start)
        begin
            cnt_next = CNT_W'(dadf_pkg::DIV_W);
            quo_next = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[dadf_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[dadf_pkg::DIV_W-2:0], 1'b0};
            end
            if (cnt_reg == CNT_W'(1))
                done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = (cnt_reg != '0);
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ----- src/detector_anchor_decode_filter_top.sv -----
// ----------------------------------------------------------------------------
// Detector anchor decode filter
// Streams detector records, tracks the best class and emits letterbox-mapped
// candidate boxes that pass both thresholds and lie inside the image.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle while no box decode is running. On the
// last class score of a record that passes the objectness and score
// thresholds, the block stops taking elements for the box decode: setup on
// one shared multiplier, then four divisions by the letterbox scale on one
// shared bit-serial divider (start, 34 quotient bits, result capture; a
// negative numerator skips its division), then a check, plus any wait for
// the output register to empty. Records that fail a threshold do not stop
// the element stream.
`timescale 1ns / 1ps
`default_nettype none
`include "detector_anchor_decode_filter_top_defines.svh"
module detector_anchor_decode_filter_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [dadf_pkg::IDX_W-1:0]      cfg_index,
    input  wire logic [dadf_pkg::CFG_W-1:0]      cfg_data,
    dadf_in_if.sink                              elem,
    dadf_out_if.source                           result
);

    localparam int PW = dadf_pkg::PROD_W;
    localparam int DW = dadf_pkg::DIM_W;

    // configuration registers
    logic [dadf_pkg::THR_W-1:0] conf_thr_reg, score_thr_reg;
    logic [dadf_pkg::NC_W-1:0]  num_cls_reg;
    logic [DW-1:0]              img_w_reg, img_h_reg, net_w_reg, net_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conf_thr_reg  <= dadf_pkg::CONF_RST;
            score_thr_reg <= dadf_pkg::SCORE_RST;
            num_cls_reg   <= dadf_pkg::NC_RST;
            img_w_reg     <= dadf_pkg::DIM_RST;
            img_h_reg     <= dadf_pkg::DIM_RST;
            net_w_reg     <= dadf_pkg::DIM_RST;
            net_h_reg     <= dadf_pkg::DIM_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                dadf_pkg::REG_CONF_THR:  conf_thr_reg  <= cfg_data;
                dadf_pkg::REG_SCORE_THR: score_thr_reg <= cfg_data;
                dadf_pkg::REG_NUM_CLS:   num_cls_reg   <= cfg_data[dadf_pkg::NC_W-1:0];
                dadf_pkg::REG_IMG_W:     img_w_reg     <= cfg_data[DW-1:0];
                dadf_pkg::REG_IMG_H:     img_h_reg     <= cfg_data[DW-1:0];
                dadf_pkg::REG_NET_W:     net_w_reg     <= cfg_data[DW-1:0];
                dadf_pkg::REG_NET_H:     net_h_reg     <= cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    // clamped geometry
    logic [DW-1:0] iw, ih, nw, nh;
    assign iw = dadf_pkg::clamp_dim(img_w_reg);
    assign ih = dadf_pkg::clamp_dim(img_h_reg);
    assign nw = dadf_pkg::clamp_dim(net_w_reg);
    assign nh = dadf_pkg::clamp_dim(net_h_reg);

    // record element tracking
    dadf_pkg::dadf_state_t state_reg, state_next;
    logic [dadf_pkg::POS_W-1:0]          pos_reg;
    logic [dadf_pkg::POS_W-1:0]          pos;
    logic [dadf_pkg::NC_W-1:0]           nc;
    logic [dadf_pkg::POS_W:0]            last;
    logic signed [dadf_pkg::ELEM_W-1:0]  box_reg [4];
    logic signed [dadf_pkg::ELEM_W-1:0]  obj_reg, best_reg, best_new;
    logic [dadf_pkg::CLS_W-1:0]          cls_reg;
    logic signed [dadf_pkg::ELEM_W-1:0]  v;
    logic                                take, is_score, is_last, pass;

    assign take = elem.valid && elem.ready;
    assign v    = elem.element_value;
    assign pos  = elem.record_start ? '0 : pos_reg;

    always_comb
    begin
        nc = num_cls_reg;
        if (nc == '0)
            nc = dadf_pkg::NC_W'(1);
        else if (nc > dadf_pkg::NC_MAX)
            nc = dadf_pkg::NC_MAX;
    end

    assign last     = 9'd4 + {1'b0, nc};
    assign is_score = ({1'b0, pos} >= 9'd5) && ({1'b0, pos} <= last);
    assign is_last  = ({1'b0, pos} == last);
    assign best_new = ((pos == 8'd5) || (v > best_reg)) ? v : best_reg;
    assign pass     = (obj_reg >= $signed({15'd0, conf_thr_reg})) &&
                      (best_new > $signed({15'd0, score_thr_reg}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            cls_reg <= '0;
        end
        else if (take)
        begin
            pos_reg <= (pos == 8'hFF) ? pos : pos + 8'd1;
            if (is_score && ((pos == 8'd5) || (v > best_reg)))
                cls_reg <= dadf_pkg::CLS_W'(pos - 8'd5);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (pos <= 8'd3)
                box_reg[pos[1:0]] <= v;
            else if (pos == 8'd4)
                obj_reg <= v;
            else if (is_score)
                best_reg <= best_new;
        end
    end

    // shared multiplier operand selection
    logic signed [dadf_pkg::MUL_A_W-1:0] mul_a;
    logic [DW-1:0]                       mul_b;
    logic signed [PW-1:0]                prod;
    logic signed [dadf_pkg::MUL_A_W-1:0] b0, b1, b2, b3;
    logic [DW-1:0]                       n_reg, d_reg;

    assign b0 = dadf_pkg::MUL_A_W'(box_reg[0]);
    assign b1 = dadf_pkg::MUL_A_W'(box_reg[1]);
    assign b2 = dadf_pkg::MUL_A_W'(box_reg[2]);
    assign b3 = dadf_pkg::MUL_A_W'(box_reg[3]);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            dadf_pkg::ST_RATIO_A: begin mul_a = {23'd0, nw}; mul_b = ih;    end
            dadf_pkg::ST_RATIO_B: begin mul_a = {23'd0, nh}; mul_b = iw;    end
            dadf_pkg::ST_XO_A:    begin mul_a = {23'd0, nw}; mul_b = d_reg; end
            dadf_pkg::ST_XO_B:    begin mul_a = {23'd0, iw}; mul_b = n_reg; end
            dadf_pkg::ST_YO_A:    begin mul_a = {23'd0, nh}; mul_b = d_reg; end
            dadf_pkg::ST_YO_B:    begin mul_a = {23'd0, ih}; mul_b = n_reg; end
            dadf_pkg::ST_X1:      begin mul_a = (b0 <<< 1) - b2; mul_b = d_reg; end
            dadf_pkg::ST_X2:      begin mul_a = (b0 <<< 1) + b2; mul_b = d_reg; end
            dadf_pkg::ST_Y1:      begin mul_a = (b1 <<< 1) - b3; mul_b = d_reg; end
            dadf_pkg::ST_Y2:      begin mul_a = (b1 <<< 1) + b3; mul_b = d_reg; end
            default: ;
        endcase
    end

    assign prod = mul_a * $signed({1'b0, mul_b});

    // geometry datapath registers
    logic signed [PW-1:0] p_reg, t_reg, xo_reg, yo_reg, iwq_reg, ihq_reg;
    logic signed [PW-1:0] x1_reg, x2_reg, y1_reg, y2_reg;
    logic [1:0]           didx_reg;
    logic [dadf_pkg::DIV_W-1:0] res_reg [4];

    // divider numerator for the current output field
    logic signed [PW-1:0] num, xr, yb;
    logic [PW:0]          rnd;
    dadf_pkg::dadf_div_req_t div_req;
    logic                       div_busy, div_done;
    logic [dadf_pkg::DIV_W-1:0] div_q;

    assign xr = (x2_reg < iwq_reg) ? x2_reg : iwq_reg;
    assign yb = (y2_reg < ihq_reg) ? y2_reg : ihq_reg;

    always_comb
    begin
        unique case (didx_reg)
            2'd0: num = x1_reg;
            2'd1: num = y1_reg;
            2'd2: num = xr - x1_reg;
            2'd3: num = yb - y1_reg;
            default: num = '0;
        endcase
    end

    // half rounding then divide by n: (num + n*2^F) / (n*2^(F+1))
    assign rnd = {1'b0, num} + ((PW+1)'(n_reg) << dadf_pkg::FRAC_BITS);
    assign div_req.start    = (state_reg == dadf_pkg::ST_DSTART) && !num[PW-1];
    assign div_req.dividend = rnd[dadf_pkg::QSH +: dadf_pkg::DIV_W];
    assign div_req.divisor  = n_reg;

    dadf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        p_reg <= prod;
        unique case (state_reg)
            dadf_pkg::ST_RATIO_B, dadf_pkg::ST_XO_B, dadf_pkg::ST_YO_B:
                t_reg <= p_reg;
            dadf_pkg::ST_SEL:
            begin
                if (t_reg <= p_reg)
                begin
                    n_reg <= nw;
                    d_reg <= iw;
                end
                else
                begin
                    n_reg <= nh;
                    d_reg <= ih;
                end
            end
            dadf_pkg::ST_XO_C:
            begin
                xo_reg  <= (t_reg - p_reg) <<< dadf_pkg::FRAC_BITS;
                iwq_reg <= p_reg <<< dadf_pkg::QSH;
            end
            dadf_pkg::ST_YO_C:
            begin
                yo_reg  <= (t_reg - p_reg) <<< dadf_pkg::FRAC_BITS;
                ihq_reg <= p_reg <<< dadf_pkg::QSH;
            end
            dadf_pkg::ST_X2:  x1_reg <= p_reg - xo_reg;
            dadf_pkg::ST_Y1:  x2_reg <= p_reg - xo_reg;
            dadf_pkg::ST_Y2:  y1_reg <= p_reg - yo_reg;
            dadf_pkg::ST_Y3:  y2_reg <= p_reg - yo_reg;
            dadf_pkg::ST_DSTART:
            begin
                // a negative numerator clamps to zero, which also rejects a size
                if (num[PW-1])
                    res_reg[didx_reg] <= '0;
            end
            dadf_pkg::ST_DWAIT:
            begin
                if (div_done)
                    res_reg[didx_reg] <= div_q;
            end
            default: ;
        endcase
    end

    // final box check
    logic [dadf_pkg::DIV_W:0] right_sum, bottom_sum;
    logic                     box_ok, slot_free;

    assign right_sum  = {1'b0, res_reg[0]} + {1'b0, res_reg[2]};
    assign bottom_sum = {1'b0, res_reg[1]} + {1'b0, res_reg[3]};
    assign box_ok     = (res_reg[2] != '0) && (res_reg[3] != '0) &&
                        (right_sum <= (dadf_pkg::DIV_W+1)'(iw)) &&
                        (bottom_sum <= (dadf_pkg::DIV_W+1)'(ih));

    // output register
    logic out_valid_reg, out_valid_next;
    logic load_out;

    assign slot_free = !out_valid_reg || result.ready;
    assign load_out  = (state_reg == dadf_pkg::ST_CHECK) && slot_free && box_ok;

    // sequencer next state
    logic [1:0] didx_next;

    always_comb
    begin
        state_next     = state_reg;
        didx_next      = didx_reg;
        out_valid_next = out_valid_reg && !result.ready;
        if (load_out)
            out_valid_next = 1'b1;
        unique case (state_reg)
            dadf_pkg::ST_ELEM:
            begin
                if (take && is_last && pass)
                    state_next = dadf_pkg::ST_RATIO_A;
            end
            dadf_pkg::ST_RATIO_A: state_next = dadf_pkg::ST_RATIO_B;
            dadf_pkg::ST_RATIO_B: state_next = dadf_pkg::ST_SEL;
            dadf_pkg::ST_SEL:     state_next = dadf_pkg::ST_XO_A;
            dadf_pkg::ST_XO_A:    state_next = dadf_pkg::ST_XO_B;
            dadf_pkg::ST_XO_B:    state_next = dadf_pkg::ST_XO_C;
            dadf_pkg::ST_XO_C:    state_next = dadf_pkg::ST_YO_A;
            dadf_pkg::ST_YO_A:    state_next = dadf_pkg::ST_YO_B;
            dadf_pkg::ST_YO_B:    state_next = dadf_pkg::ST_YO_C;
            dadf_pkg::ST_YO_C:    state_next = dadf_pkg::ST_X1;
            dadf_pkg::ST_X1:      state_next = dadf_pkg::ST_X2;
            dadf_pkg::ST_X2:      state_next = dadf_pkg::ST_Y1;
            dadf_pkg::ST_Y1:      state_next = dadf_pkg::ST_Y2;
            dadf_pkg::ST_Y2:      state_next = dadf_pkg::ST_Y3;
            dadf_pkg::ST_Y3:
            begin
                didx_next  = 2'd0;
                state_next = dadf_pkg::ST_DSTART;
            end
            dadf_pkg::ST_DSTART:
            begin
                if (!num[PW-1])
                    state_next = dadf_pkg::ST_DWAIT;
                else if (didx_reg == 2'd3)
                    state_next = dadf_pkg::ST_CHECK;
                else
                    didx_next = didx_reg + 2'd1;
            end
            dadf_pkg::ST_DWAIT:
            begin
                if (div_done)
                begin
                    if (didx_reg == 2'd3)
                        state_next = dadf_pkg::ST_CHECK;
                    else
                    begin
                        didx_next  = didx_reg + 2'd1;
                        state_next = dadf_pkg::ST_DSTART;
                    end
                end
            end
            dadf_pkg::ST_CHECK:
            begin
                if (slot_free)
                    state_next = dadf_pkg::ST_ELEM;
            end
            default: state_next = dadf_pkg::ST_ELEM;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dadf_pkg::ST_ELEM;
            didx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            didx_reg      <= didx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    logic [dadf_pkg::CLS_W-1:0] o_cls_reg;
    logic [dadf_pkg::THR_W-1:0] o_conf_reg;
    logic [DW-2:0]              o_left_reg, o_top_reg;
    logic [DW-1:0]              o_w_reg, o_h_reg;

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            o_cls_reg  <= cls_reg;
            o_conf_reg <= (obj_reg > $signed(dadf_pkg::ONE_FIX)) ?
                          dadf_pkg::ONE_FIX[dadf_pkg::THR_W-1:0] :
                          obj_reg[dadf_pkg::THR_W-1:0];
            o_left_reg <= res_reg[0][DW-2:0];
            o_top_reg  <= res_reg[1][DW-2:0];
            o_w_reg    <= res_reg[2][DW-1:0];
            o_h_reg    <= res_reg[3][DW-1:0];
        end
    end

    assign elem.ready         = (state_reg == dadf_pkg::ST_ELEM);
    assign result.valid       = out_valid_reg;
    assign result.cls_index   = o_cls_reg;
    assign result.confidence  = o_conf_reg;
    assign result.box_left    = o_left_reg;
    assign result.box_top     = o_top_reg;
    assign result.box_width   = o_w_reg;
    assign result.box_height  = o_h_reg;

    // checks
    `DADF_ASSERT_IMP(a_div_idle_in_elem, div_busy, state_reg != dadf_pkg::ST_ELEM)
    `DADF_ASSERT_IMP(a_rose_from_check, $rose(out_valid_reg), $past(state_reg) == dadf_pkg::ST_CHECK)
    `DADF_ASSERT_IMP(a_nonzero_box, out_valid_reg, (o_w_reg != '0) && (o_h_reg != '0))
    `DADF_ASSERT_NXT(a_load_sets_valid, load_out, out_valid_reg)

endmodule
`default_nettype wire
